@@ rtl/lhce_pkg.sv @@
// ----------------------------------------------------------------------------
// lhce_pkg
// Shared types and constants of the LZSS history copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lhce_pkg;

    localparam int RING_AW_DEF = 13;

    // Widest decoded offset: length code 15 gives 2^14 plus 12 extra bits.
    localparam int OFF_W = 15;

    localparam logic [8:0] LITERAL_LIMIT = 9'd256;
    localparam logic [8:0] MIN_COPY      = 9'd3;
    localparam logic [8:0] MAX_SYMBOL    = 9'd509;
    localparam logic [8:0] COPY_BIAS     = LITERAL_LIMIT - MIN_COPY;
    localparam logic [7:0] FILL_BYTE     = 8'h20;

    typedef struct packed {
        logic [8:0]  symbol;
        logic [3:0]  offset_length;
        logic [11:0] offset_extra;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [2:0] byte_count;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/lhce_history_ram.sv @@
// ----------------------------------------------------------------------------
// lhce_history_ram
// History ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lhce_history_ram #(
    parameter int RING_AW = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [RING_AW-1:0] i_waddr,
    input  wire logic [7:0]         i_wdata,
    input  wire logic               i_re,
    input  wire logic [RING_AW-1:0] i_raddr,
    output logic      [7:0]         o_rdata
);
    localparam int DEPTH = 1 << RING_AW;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the read data while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/lhce_copy_ctrl.sv @@
// ----------------------------------------------------------------------------
// lhce_copy_ctrl
// Command sequencer: clears the ring after reset, decodes the copy distance,
// issues ring reads, writes every produced byte back and packs bytes in fours.
// ----------------------------------------------------------------------------
`default_nettype none

module lhce_copy_ctrl #(
    parameter int RING_AW = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    input  wire lhce_pkg::t_in_item        i_cmd,
    output logic                           o_cmd_stall,
    input  wire logic                      i_out_free,
    output logic                           o_grp_valid,
    output lhce_pkg::t_out_item            o_grp,
    output logic                           o_mem_we,
    output logic      [RING_AW-1:0]        o_mem_waddr,
    output logic      [7:0]                o_mem_wdata,
    output logic                           o_mem_re,
    output logic      [RING_AW-1:0]        o_mem_raddr,
    input  wire logic [7:0]                i_mem_rdata
);
    import lhce_pkg::*;

    localparam int HB  = RING_AW;
    localparam int WW  = (HB > OFF_W) ? HB : OFF_W;

    // Clearing pass
    logic          r_clr_busy;
    logic [HB-1:0] r_clr_addr;

    // Issue side
    logic          r_active;
    logic          r_a_first;
    logic          r_lit;
    logic [7:0]    r_lit_byte;
    logic          r_fwd;
    logic [HB-1:0] r_rd_addr;
    logic [8:0]    r_left;

    // Write-back side
    logic          r_b_vld;
    logic          r_b_first;
    logic          r_b_last;
    logic [7:0]    r_prev;
    logic [HB-1:0] r_wp;
    logic [1:0]    r_slot;
    logic [7:0]    r_grp [4];

    // Command decode
    logic [8:0]     sym_sat;
    logic [8:0]     cmd_count;
    logic [3:0]     nbits;
    logic [OFF_W-1:0] ext;
    logic [OFF_W-1:0] offset;
    logic [WW-1:0]  offset_w;
    logic [HB-1:0]  copy_dist;
    logic [HB-1:0]  start;
    logic           is_lit;

    logic           accept;
    logic           grp_done;
    logic           b_go;
    logic           a_go;
    logic [7:0]     b_byte;
    logic [7:0]     gb [4];

    always_comb begin
        is_lit    = (i_cmd.symbol < LITERAL_LIMIT);
        sym_sat   = (i_cmd.symbol > MAX_SYMBOL) ? MAX_SYMBOL : i_cmd.symbol;
        cmd_count = sym_sat - COPY_BIAS;
        nbits     = i_cmd.offset_length - 4'd1;
        ext       = OFF_W'(i_cmd.offset_extra);
        if (i_cmd.offset_length < 4'd2) begin
            offset = OFF_W'(i_cmd.offset_length);
        end else begin
            for (int j = 0; j < OFF_W; j++) begin
                offset[j] = (j < int'(nbits)) ? ext[j] : (j == int'(nbits));
            end
        end
        offset_w  = WW'(offset);
        copy_dist = offset_w[HB-1:0];
        start     = r_wp - copy_dist - HB'(1);
    end

    assign o_cmd_stall = r_clr_busy || r_active || r_b_vld;
    assign accept      = i_cmd_valid && !o_cmd_stall;

    // A finished group needs the output register; otherwise hold both sides.
    assign grp_done = (r_slot == 2'd3) || r_b_last;
    assign b_go     = r_b_vld && (!grp_done || i_out_free);
    assign a_go     = r_active && (!r_b_vld || b_go);

    // Distance one: the byte needed was written in the same cycle as the read.
    assign b_byte = r_lit                 ? r_lit_byte :
                    (r_fwd && !r_b_first) ? r_prev     : i_mem_rdata;

    always_comb begin
        for (int s = 0; s < 4; s++) begin
            if (s < int'(r_slot)) begin
                gb[s] = r_grp[s];
            end else if (s == int'(r_slot)) begin
                gb[s] = b_byte;
            end else begin
                gb[s] = 8'h00;
            end
        end
        o_grp.byte0      = gb[0];
        o_grp.byte1      = gb[1];
        o_grp.byte2      = gb[2];
        o_grp.byte3      = gb[3];
        o_grp.byte_count = 3'(r_slot) + 3'd1;
        o_grp.last       = r_b_last;
    end

    assign o_grp_valid = b_go && grp_done;

    assign o_mem_re    = a_go;
    assign o_mem_raddr = r_rd_addr;
    assign o_mem_we    = r_clr_busy || b_go;
    assign o_mem_waddr = r_clr_busy ? r_clr_addr : r_wp;
    assign o_mem_wdata = r_clr_busy ? FILL_BYTE : b_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + HB'(1);
            if (r_clr_addr == {HB{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_a_first <= 1'b0;
            r_b_vld   <= 1'b0;
            r_b_first <= 1'b0;
            r_b_last  <= 1'b0;
            r_wp      <= '0;
            r_slot    <= 2'd0;
        end else begin
            if (accept) begin
                r_active  <= 1'b1;
                r_a_first <= 1'b1;
            end else if (a_go) begin
                r_a_first <= 1'b0;
                if (r_left == 9'd1) begin
                    r_active <= 1'b0;
                end
            end

            if (a_go) begin
                r_b_vld   <= 1'b1;
                r_b_first <= r_a_first;
                r_b_last  <= (r_left == 9'd1);
            end else if (b_go) begin
                r_b_vld <= 1'b0;
            end

            if (b_go) begin
                r_wp   <= r_wp + HB'(1);
                r_slot <= grp_done ? 2'd0 : r_slot + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lit      <= is_lit;
            r_lit_byte <= i_cmd.symbol[7:0];
            r_fwd      <= (copy_dist == '0);
            r_rd_addr  <= start;
            r_left     <= is_lit ? 9'd1 : cmd_count;
        end else if (a_go) begin
            r_rd_addr <= r_rd_addr + HB'(1);
            r_left    <= r_left - 9'd1;
        end
        if (b_go) begin
            r_prev         <= b_byte;
            r_grp[r_slot]  <= b_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lzss_history_copy_engine.sv @@
// ----------------------------------------------------------------------------
// lzss_history_copy_engine
// Back end of an LZSS decoder: literals and history copies, bytes out in fours.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / i_in_data / o_in_stall) takes one decoded
// command: a literal byte, or a copy of symbol-253 bytes from the history
// ring at distance offset+1. Output channel (o_out_valid / o_out_data /
// i_out_stall) returns groups of up to four bytes in order; the final group
// of each command has last set.
// The ring is read and written one byte per cycle while the output register
// does not hold them back, through a single-port-pair RAM; a command holds
// the input until its last byte is written back.
// After reset the block sweeps all 2^RING_AW ring entries (8192 by default)
// to spaces, one entry per cycle; o_in_stall stays high meanwhile.
// The write position restarts at zero.
// A result waits in an output register; a new command may be taken while it
// waits. When the receiver stalls with a group waiting and the next group is
// complete, the ring reads and write-back pause until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_history_copy_engine #(
    parameter int RING_AW = lhce_pkg::RING_AW_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire lhce_pkg::t_in_item  i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output lhce_pkg::t_out_item      o_out_data,
    input  wire logic                i_out_stall
);
    import lhce_pkg::*;

    logic               mem_we;
    logic [RING_AW-1:0] mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [RING_AW-1:0] mem_raddr;
    logic [7:0]         mem_rdata;

    logic      grp_valid;
    t_out_item grp;
    logic      out_free;

    logic      r_out_vld;
    t_out_item r_out_data;

    lhce_history_ram #(
        .RING_AW(RING_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lhce_copy_ctrl #(
        .RING_AW(RING_AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .i_cmd       (i_in_data),
        .o_cmd_stall (o_in_stall),
        .i_out_free  (out_free),
        .o_grp_valid (grp_valid),
        .o_grp       (grp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (grp_valid) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_valid) begin
            r_out_data <= grp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
